/* sv/circle_octant_step_top_macros.svh */
// Assertion macros for circle_octant_step_top and its checker.
// Needs clk and rst_n in scope at the point of use.
`ifndef CIRCLE_OCTANT_STEP_TOP_MACROS_SVH
`define CIRCLE_OCTANT_STEP_TOP_MACROS_SVH

// ante in one cycle implies cons in the next, outside reset
`define COCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circle_octant_step: assertion failed");

// a stalled beat keeps sig unchanged
`define COCT_ASSERT_HOLD(lbl, vld, rdy, sig) \
    `COCT_ASSERT_NEXT(lbl, (vld) && !(rdy), $stable(sig))

`endif

/* sv/coct_pkg.sv */
// Shared sizes, types and helpers for the circle octant step block.
// No dependencies.
`timescale 1ns / 1ps

package coct_pkg;

    localparam int RADIUS_BITS  = 12;
    localparam int COORD_BITS   = 16;
    localparam int COLOR_W      = 32;
    localparam int SQ_W         = 2 * RADIUS_BITS;
    localparam int OUT_W        = COORD_BITS + 1;
    localparam int EXT_W        = (RADIUS_BITS + 1 > OUT_W) ? RADIUS_BITS + 1 : OUT_W;
    localparam int PIX_PER_STEP = 8;
    localparam int PIX_IDX_W    = $clog2(PIX_PER_STEP);
    localparam logic [PIX_IDX_W-1:0] PIX_LAST = PIX_IDX_W'(PIX_PER_STEP - 1);

    typedef logic [RADIUS_BITS-1:0]      rad_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]     pix_t;
    typedef logic [SQ_W-1:0]             sq_t;
    typedef logic [COLOR_W-1:0]          color_t;

    typedef struct packed {
        sq_t    rem;
        sq_t    root;
        sq_t    trial;
        rad_t   offset;
        coord_t cx;
        coord_t cy;
        color_t color;
        logic   fin;
    } root_work_t;

    function automatic pix_t widen(input rad_t v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[OUT_W-1:0];
    endfunction

endpackage

/* sv/coct_prep.sv */
// Front stages: squares of radius and offset, octant bound test, root seed.
// Depends on coct_pkg.
`timescale 1ns / 1ps

module coct_prep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  coct_pkg::coord_t     center_x,
    input  coct_pkg::coord_t     center_y,
    input  coct_pkg::rad_t       radius,
    input  coct_pkg::rad_t       step_offset,
    input  coct_pkg::color_t     color,
    output logic                 out_valid,
    output coct_pkg::root_work_t out_data
);

    logic                 a_valid_reg;
    coct_pkg::sq_t        a_xx_reg;
    coct_pkg::sq_t        a_rr_reg;
    coct_pkg::rad_t       a_x_reg;
    coct_pkg::coord_t     a_cx_reg;
    coct_pkg::coord_t     a_cy_reg;
    coct_pkg::color_t     a_color_reg;

    logic                 b_valid_reg;
    logic                 b_valid_next;
    coct_pkg::root_work_t b_data_reg;
    coct_pkg::root_work_t b_data_next;

    logic [coct_pkg::SQ_W:0]   xx2;
    logic [coct_pkg::SQ_W:0]   nxx;
    logic [coct_pkg::SQ_W+1:0] nxx2;
    logic                      in_oct;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_xx_reg    <= coct_pkg::SQ_W'(step_offset) * coct_pkg::SQ_W'(step_offset);
            a_rr_reg    <= coct_pkg::SQ_W'(radius) * coct_pkg::SQ_W'(radius);
            a_x_reg     <= step_offset;
            a_cx_reg    <= center_x;
            a_cy_reg    <= center_y;
            a_color_reg <= color;
            b_data_reg  <= b_data_next;
        end
    end

    always_comb begin
        xx2    = {a_xx_reg, 1'b0};
        nxx    = (coct_pkg::SQ_W + 1)'(a_xx_reg)
               + (coct_pkg::SQ_W + 1)'({a_x_reg, 1'b0})
               + (coct_pkg::SQ_W + 1)'(1);
        nxx2   = {nxx, 1'b0};
        in_oct = xx2 <= {1'b0, a_rr_reg};

        b_valid_next       = a_valid_reg && in_oct;
        b_data_next.rem    = a_rr_reg - a_xx_reg;
        b_data_next.root   = '0;
        b_data_next.trial  = coct_pkg::sq_t'(1) << (coct_pkg::SQ_W - 2);
        b_data_next.offset = a_x_reg;
        b_data_next.cx     = a_cx_reg;
        b_data_next.cy     = a_cy_reg;
        b_data_next.color  = a_color_reg;
        b_data_next.fin    = nxx2 > (coct_pkg::SQ_W + 2)'(a_rr_reg);
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

/* sv/coct_cell.sv */
// One square root cell: settles one root bit and hands the work on.
// Depends on coct_pkg.
`timescale 1ns / 1ps

module coct_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  coct_pkg::root_work_t in_data,
    output logic                 out_valid,
    output coct_pkg::root_work_t out_data
);

    logic                      valid_reg;
    coct_pkg::root_work_t      data_reg;
    coct_pkg::root_work_t      data_next;
    logic [coct_pkg::SQ_W:0]   sum;
    logic                      take;

    always_comb begin
        sum       = (coct_pkg::SQ_W + 1)'(in_data.root) + (coct_pkg::SQ_W + 1)'(in_data.trial);
        take      = {1'b0, in_data.rem} >= sum;
        data_next = in_data;
        if (take) begin
            data_next.rem  = in_data.rem - sum[coct_pkg::SQ_W-1:0];
            data_next.root = (in_data.root >> 1) + in_data.trial;
        end
        else begin
            data_next.root = in_data.root >> 1;
        end
        data_next.trial = in_data.trial >> 2;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/coct_emit.sv */
// Pixel emitter: holds one finished step and sends its eight mirrored pixels.
// Depends on coct_pkg.
`timescale 1ns / 1ps

module coct_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  coct_pkg::root_work_t in_data,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output coct_pkg::pix_t       pixel_x,
    output coct_pkg::pix_t       pixel_y,
    output coct_pkg::color_t     pixel_color,
    output logic                 run_end,
    output logic                 final_step
);

    logic                             busy_reg;
    logic                             busy_next;
    logic [coct_pkg::PIX_IDX_W-1:0]   idx_reg;
    logic [coct_pkg::PIX_IDX_W-1:0]   idx_next;
    coct_pkg::rad_t                   x_reg;
    coct_pkg::rad_t                   y_reg;
    coct_pkg::coord_t                 cx_reg;
    coct_pkg::coord_t                 cy_reg;
    coct_pkg::color_t                 color_reg;
    logic                             fin_reg;

    logic           last;
    logic           swap;
    logic           neg_x;
    logic           neg_y;
    coct_pkg::pix_t dx_mag;
    coct_pkg::pix_t dy_mag;
    coct_pkg::pix_t dx;
    coct_pkg::pix_t dy;

    assign last = idx_reg == coct_pkg::PIX_LAST;
    assign take = !busy_reg || (out_ready && last);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (in_valid && take) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready) begin
            busy_next = !last;
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && take) begin
            x_reg     <= in_data.offset;
            y_reg     <= in_data.root[coct_pkg::RADIUS_BITS-1:0];
            cx_reg    <= in_data.cx;
            cy_reg    <= in_data.cy;
            color_reg <= in_data.color;
            fin_reg   <= in_data.fin;
        end
    end

    // order: (x,-y) (y,-x) (y,x) (x,y) (-x,y) (-y,x) (-y,-x) (-x,-y)
    always_comb begin
        swap   = idx_reg[0] ^ idx_reg[1];
        neg_x  = idx_reg[2];
        neg_y  = !(idx_reg[1] ^ idx_reg[2]);
        dx_mag = coct_pkg::widen(swap ? y_reg : x_reg);
        dy_mag = coct_pkg::widen(swap ? x_reg : y_reg);
        dx     = neg_x ? -dx_mag : dx_mag;
        dy     = neg_y ? -dy_mag : dy_mag;
    end

    assign out_valid   = busy_reg;
    assign pixel_x     = coct_pkg::pix_t'({cx_reg[coct_pkg::COORD_BITS-1], cx_reg}) + dx;
    assign pixel_y     = coct_pkg::pix_t'({cy_reg[coct_pkg::COORD_BITS-1], cy_reg}) + dy;
    assign pixel_color = color_reg;
    assign run_end     = last;
    assign final_step  = fin_reg;

endmodule

/* sv/circle_octant_step_top.sv */
// Circle octant step: squares, a chain of square root cells, pixel emitter.
// Depends on coct_pkg, coct_prep, coct_cell and coct_emit.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one circle step per beat: center,
//   radius, color and the octant offset x. Output channel (out_valid/out_ready)
//   gives one pixel per beat. A step inside the octant (2*x*x <= r*r) yields
//   eight mirrored pixels, the last with run_end set; final_step marks the
//   last step of the octant. A step past the bound yields no beat.
//   Path: an input beat passes two front stages, one square root cell per
//   root bit and the emitter load, which raises out_valid for its pixels.
//   Throughput: the emitter sends one pixel per cycle while out_ready is high
//   and takes the next step only with the last pixel of the current one;
//   steps that yield no pixels flow through at one per cycle unless stalled.
//   Stall: out_ready low holds the current pixel; the chain keeps filling
//   until its last cell holds a finished step, then in_ready drops.
//   Reset: clears all valid flags and the emitter; no step is in flight after.
`timescale 1ns / 1ps

module circle_octant_step_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  coct_pkg::coord_t center_x,
    input  coct_pkg::coord_t center_y,
    input  coct_pkg::rad_t   radius,
    input  coct_pkg::rad_t   step_offset,
    input  coct_pkg::color_t color,
    output logic             out_valid,
    input  logic             out_ready,
    output coct_pkg::pix_t   pixel_x,
    output coct_pkg::pix_t   pixel_y,
    output coct_pkg::color_t pixel_color,
    output logic             run_end,
    output logic             final_step
);

    logic                                en;
    logic                                emit_take;
    logic                                seed_valid;
    coct_pkg::root_work_t                seed_data;
    logic [coct_pkg::RADIUS_BITS-1:0]    cell_valid;
    coct_pkg::root_work_t                cell_data [coct_pkg::RADIUS_BITS];

    assign en       = !cell_valid[coct_pkg::RADIUS_BITS-1] || emit_take;
    assign in_ready = en;

    coct_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .step_offset (step_offset),
        .color       (color),
        .out_valid   (seed_valid),
        .out_data    (seed_data)
    );

    for (genvar i = 0; i < coct_pkg::RADIUS_BITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            coct_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (seed_valid),
                .in_data   (seed_data),
                .out_valid (cell_valid[i]),
                .out_data  (cell_data[i])
            );
        end
        else begin : g_next
            coct_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (cell_valid[i-1]),
                .in_data   (cell_data[i-1]),
                .out_valid (cell_valid[i]),
                .out_data  (cell_data[i])
            );
        end
    end

    coct_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cell_valid[coct_pkg::RADIUS_BITS-1]),
        .in_data     (cell_data[coct_pkg::RADIUS_BITS-1]),
        .take        (emit_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .run_end     (run_end),
        .final_step  (final_step)
    );

endmodule

/* sv/coct_checker.sv */
// Port checker for circle_octant_step_top, attached by bind.
// Depends on coct_pkg and circle_octant_step_top_macros.svh.
`timescale 1ns / 1ps
`include "circle_octant_step_top_macros.svh"

module coct_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input coct_pkg::pix_t   pixel_x,
    input coct_pkg::pix_t   pixel_y,
    input coct_pkg::color_t pixel_color,
    input logic             run_end,
    input logic             final_step
);

    `COCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `COCT_ASSERT_HOLD(a_pix_hold, out_valid, out_ready, {pixel_x, pixel_y})
    `COCT_ASSERT_NEXT(a_run_cont, out_valid && out_ready && !run_end, out_valid)
    `COCT_ASSERT_NEXT(a_run_same, out_valid && out_ready && !run_end,
                      $stable(pixel_color) && $stable(final_step))

endmodule

bind circle_octant_step_top coct_checker u_coct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .run_end     (run_end),
    .final_step  (final_step)
);
